/* design/dmpm_pkg.sv */
// dmpm_pkg: shared types, constants and helpers for the DFA multi-pattern matcher.
// Used by every module of the design; depends on nothing.
package dmpm_pkg;

    localparam int NUM_STATES   = 256;
    localparam int MAX_PATTERNS = 32;

    localparam int STATE_W  = 8;
    localparam int SYM_W    = 8;
    localparam int TAG_W    = 6;
    localparam int IDX_W    = 5;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam int STATE_AW = $clog2(NUM_STATES);
    localparam int TRANS_AW = STATE_AW + SYM_W;
    localparam int TRANS_DEPTH = NUM_STATES * (2 ** SYM_W);

    localparam int OUTQ_DEPTH  = 4;
    localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 3);

    typedef enum logic [1:0] {
        CMD_WR_TRANS = 2'd0,
        CMD_WR_TAG   = 2'd1,
        CMD_TEXT     = 2'd2,
        CMD_END      = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_STATE = 2'd0,
        CFG_START_SYM   = 2'd1,
        CFG_END_SYM     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_cmd                command;
        logic [STATE_W-1:0]  table_state;
        logic [SYM_W-1:0]    table_symbol;
        logic [STATE_W-1:0]  table_next_state;
        logic                table_next_valid;
        logic [TAG_W-1:0]    table_final_tag;
        logic [SYM_W-1:0]    text_byte;
        logic                first_of_string;
    } t_in_req;

    typedef struct packed {
        logic             match_found;
        logic [IDX_W-1:0] pattern_index;
    } t_result;

    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] next;
    } t_trans_entry;

    function automatic logic state_ok(input logic [STATE_W-1:0] s);
        return (int'(s) < NUM_STATES);
    endfunction

    function automatic logic [TRANS_AW-1:0] trans_addr(input logic [STATE_W-1:0] s,
                                                       input logic [SYM_W-1:0]   sym);
        return {STATE_AW'(s), sym};
    endfunction

endpackage

/* design/dmpm_trans_mem.sv */
// dmpm_trans_mem: single-port synchronous transition table with a registered read port.
// Depends on dmpm_pkg for the entry type and depth.
module dmpm_trans_mem (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_we,
    input  logic [dmpm_pkg::TRANS_AW-1:0] i_addr,
    input  dmpm_pkg::t_trans_entry        i_wdata,
    output dmpm_pkg::t_trans_entry        o_rdata
);

    dmpm_pkg::t_trans_entry r_mem [dmpm_pkg::TRANS_DEPTH];
    dmpm_pkg::t_trans_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/dmpm_tag_mem.sv */
// dmpm_tag_mem: per-state final tag store, one write port and one registered read port.
// Depends on dmpm_pkg for widths and depth.
module dmpm_tag_mem (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [dmpm_pkg::STATE_AW-1:0] i_waddr,
    input  logic [dmpm_pkg::TAG_W-1:0]    i_wdata,
    input  logic                          i_re,
    input  logic [dmpm_pkg::STATE_AW-1:0] i_raddr,
    output logic [dmpm_pkg::TAG_W-1:0]    o_rdata
);

    logic [dmpm_pkg::TAG_W-1:0] r_mem [dmpm_pkg::NUM_STATES];
    logic [dmpm_pkg::TAG_W-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/dmpm_out_queue.sv */
// dmpm_out_queue: small result queue that decouples the matcher from the receiver's stall.
// Depends on dmpm_pkg for the result type and queue depth.
module dmpm_out_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  dmpm_pkg::t_result               i_push_data,
    input  logic                            i_stall,
    output logic                            o_valid,
    output dmpm_pkg::t_result               o_res,
    output logic [dmpm_pkg::OUTQ_CNT_W-1:0] o_count
);

    dmpm_pkg::t_result                r_buf [dmpm_pkg::OUTQ_DEPTH];
    logic [dmpm_pkg::OUTQ_PTR_W-1:0]  r_head;
    logic [dmpm_pkg::OUTQ_PTR_W-1:0]  r_tail;
    logic [dmpm_pkg::OUTQ_CNT_W-1:0]  r_count;
    logic                             pop;

    assign o_valid = (r_count != '0);
    assign o_res   = r_buf[r_head];
    assign o_count = r_count;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_tail] <= i_push_data;
        end
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (pop) begin
                r_head <= r_head + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* design/dfa_multi_pattern_matcher.sv */
// dfa_multi_pattern_matcher: top level of the table-driven multi-pattern matcher.
// Depends on dmpm_pkg, dmpm_trans_mem, dmpm_tag_mem and dmpm_out_queue.
//
// Usage
//   Request channel (i_valid, o_stall, i_req): each request either writes one
//   transition entry, writes one state's final tag, steps one text byte or ends
//   the string. A request is taken at a clock edge with i_valid high and o_stall low.
//   Result channel (o_valid, i_stall, o_res): one result per end-of-string request,
//   taken at an edge with o_valid high and i_stall low.
//   Configuration port (i_cfg_we, i_cfg_idx, i_cfg_wdata): write start state,
//   start marker and end marker while the block is idle.
// Timing
//   Every automaton step is one read of the transition memory; its next state is
//   forwarded straight into the address of the following step, so steps issue one
//   per cycle while the result queue has room. A request that opens a string issues
//   the start marker step first and its own step after it, with o_stall holding the
//   next request meanwhile. o_valid rises once the end step has passed stages B and C
//   and its result is in the queue. The final tag lookup runs one stage behind the read.
// Reset and stall
//   Synchronous reset clears the matching state and pipeline and loads the
//   default configuration; the table memories are not cleared and hold anything
//   until written. Results wait in a four-deep queue while the receiver stalls;
//   o_stall rises while a held step is pending, or once that queue and the end steps in flight could fill it.
module dfa_multi_pattern_matcher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  dmpm_pkg::t_in_req               i_req,
    output logic                            o_valid,
    input  logic                            i_stall,
    output dmpm_pkg::t_result               o_res,
    input  logic                            i_cfg_we,
    input  logic [dmpm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dmpm_pkg::CFG_W-1:0]      i_cfg_wdata
);

    // step pipeline stage after the transition read is issued
    typedef struct packed {
        logic                         v;
        logic                         start;
        logic                         is_end;
        logic                         alive;
        logic [dmpm_pkg::STATE_W-1:0] cur;
    } t_stage_b;

    // stage after the final tag read is issued
    typedef struct packed {
        logic v;
        logic start;
        logic is_end;
        logic enter;
    } t_stage_c;

    // configuration
    logic [dmpm_pkg::STATE_W-1:0] r_start_state;
    logic [dmpm_pkg::SYM_W-1:0]   r_start_sym;
    logic [dmpm_pkg::SYM_W-1:0]   r_end_sym;

    // matching state
    logic [dmpm_pkg::STATE_W-1:0] r_cur;
    logic                         r_alive;
    logic [dmpm_pkg::TAG_W-1:0]   r_best;

    // second step of a request that opens a string
    logic                         r_pend_v;
    logic                         r_pend_end;
    logic [dmpm_pkg::SYM_W-1:0]   r_pend_sym;
    logic                         n_pend_v;
    logic                         n_pend_end;
    logic [dmpm_pkg::SYM_W-1:0]   n_pend_sym;

    t_stage_b r_b;
    t_stage_c r_c;

    // issue
    logic                         accept;
    logic                         credit;
    logic [dmpm_pkg::OUTQ_CNT_W-1:0] occ;
    logic [dmpm_pkg::OUTQ_CNT_W-1:0] q_count;
    logic                         iss_v;
    logic                         iss_start;
    logic                         iss_end;
    logic [dmpm_pkg::SYM_W-1:0]   iss_sym;
    logic                         tr_we;
    logic                         tag_we;
    logic [dmpm_pkg::STATE_W-1:0] eff_cur;
    logic                         eff_alive;

    // memories
    logic                         tr_en;
    logic [dmpm_pkg::TRANS_AW-1:0] tr_addr;
    dmpm_pkg::t_trans_entry       tr_wdata;
    dmpm_pkg::t_trans_entry       tr_rdata;
    logic [dmpm_pkg::TAG_W-1:0]   tag_wdata;
    logic [dmpm_pkg::TAG_W-1:0]   tag_rdata;

    // stage B results
    logic                         b_enter;
    logic                         b_alive;
    logic [dmpm_pkg::STATE_W-1:0] b_cur;

    // stage C results
    logic [dmpm_pkg::TAG_W-1:0]   c_base;
    logic [dmpm_pkg::TAG_W-1:0]   c_best;
    logic [dmpm_pkg::TAG_W-1:0]   c_idx;
    logic                         push;
    dmpm_pkg::t_result            push_data;

    // Room for one more end step: queue entries plus end steps still in flight.
    assign occ = q_count
               + dmpm_pkg::OUTQ_CNT_W'(r_b.v && r_b.is_end)
               + dmpm_pkg::OUTQ_CNT_W'(r_c.v && r_c.is_end);
    assign credit  = (occ < dmpm_pkg::OUTQ_CNT_W'(dmpm_pkg::OUTQ_DEPTH));
    assign o_stall = r_pend_v || !credit;
    assign accept  = i_valid && !o_stall;

    // Split each request into memory writes and automaton steps.
    always_comb begin
        iss_v      = 1'b0;
        iss_start  = 1'b0;
        iss_end    = 1'b0;
        iss_sym    = i_req.text_byte;
        tr_we      = 1'b0;
        tag_we     = 1'b0;
        n_pend_v   = r_pend_v;
        n_pend_end = r_pend_end;
        n_pend_sym = r_pend_sym;
        if (r_pend_v) begin
            if (!r_pend_end || credit) begin
                iss_v    = 1'b1;
                iss_end  = r_pend_end;
                iss_sym  = r_pend_end ? r_end_sym : r_pend_sym;
                n_pend_v = 1'b0;
            end
        end else if (accept) begin
            case (i_req.command)
                dmpm_pkg::CMD_WR_TRANS: begin
                    tr_we = dmpm_pkg::state_ok(i_req.table_state);
                end
                dmpm_pkg::CMD_WR_TAG: begin
                    tag_we = dmpm_pkg::state_ok(i_req.table_state);
                end
                dmpm_pkg::CMD_TEXT, dmpm_pkg::CMD_END: begin
                    iss_v = 1'b1;
                    if (i_req.first_of_string) begin
                        // start marker goes first; hold the real step
                        iss_start  = 1'b1;
                        iss_sym    = r_start_sym;
                        n_pend_v   = 1'b1;
                        n_pend_end = (i_req.command == dmpm_pkg::CMD_END);
                        n_pend_sym = i_req.text_byte;
                    end else begin
                        iss_end = (i_req.command == dmpm_pkg::CMD_END);
                        iss_sym = (i_req.command == dmpm_pkg::CMD_END) ? r_end_sym
                                                                      : i_req.text_byte;
                    end
                end
                default: begin
                    iss_v = 1'b0;
                end
            endcase
        end
    end

    // Current state seen by the issuing step: a new string starts afresh,
    // otherwise take the step finishing in stage B ahead of the registers.
    always_comb begin
        if (iss_start) begin
            eff_cur   = r_start_state;
            eff_alive = dmpm_pkg::state_ok(r_start_state);
        end else if (r_b.v) begin
            eff_cur   = b_cur;
            eff_alive = b_alive;
        end else begin
            eff_cur   = r_cur;
            eff_alive = r_alive;
        end
    end

    assign tr_en          = iss_v || tr_we;
    assign tr_addr        = tr_we ? dmpm_pkg::trans_addr(i_req.table_state, i_req.table_symbol)
                                  : dmpm_pkg::trans_addr(eff_cur, iss_sym);
    assign tr_wdata.valid = i_req.table_next_valid;
    assign tr_wdata.next  = i_req.table_next_state;

    // Clamp tags above the pattern count on the way in.
    assign tag_wdata = (int'(i_req.table_final_tag) > dmpm_pkg::MAX_PATTERNS)
                     ? dmpm_pkg::TAG_W'(dmpm_pkg::MAX_PATTERNS) : i_req.table_final_tag;

    dmpm_trans_mem u_trans_mem (
        .i_clk   (i_clk),
        .i_en    (tr_en),
        .i_we    (tr_we),
        .i_addr  (tr_addr),
        .i_wdata (tr_wdata),
        .o_rdata (tr_rdata)
    );

    // Stage B: resolve the transition; a missing or out-of-range one kills the string.
    assign b_enter = r_b.alive && tr_rdata.valid && dmpm_pkg::state_ok(tr_rdata.next);
    assign b_cur   = b_enter ? tr_rdata.next : r_b.cur;
    assign b_alive = b_enter && !r_b.is_end;

    dmpm_tag_mem u_tag_mem (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (dmpm_pkg::STATE_AW'(i_req.table_state)),
        .i_wdata (tag_wdata),
        .i_re    (r_b.v),
        .i_raddr (dmpm_pkg::STATE_AW'(tr_rdata.next)),
        .o_rdata (tag_rdata)
    );

    // Stage C: raise the best tag; an end step reports and clears it.
    assign c_base = r_c.start ? '0 : r_best;
    assign c_best = (r_c.enter && (tag_rdata > c_base)) ? tag_rdata : c_base;
    assign c_idx  = c_best - 1'b1;
    assign push   = r_c.v && r_c.is_end;

    always_comb begin
        push_data.match_found   = (c_best != '0);
        push_data.pattern_index = '0;
        if (c_best != '0) begin
            push_data.pattern_index = (c_idx > dmpm_pkg::TAG_W'((2 ** dmpm_pkg::IDX_W) - 1))
                                    ? '1 : c_idx[dmpm_pkg::IDX_W-1:0];
        end
    end

    dmpm_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_res       (o_res),
        .o_count     (q_count)
    );

    always_ff @(posedge i_clk) begin
        // payload of the pipeline stages
        r_b.start  <= iss_start;
        r_b.is_end <= iss_end;
        r_b.alive  <= eff_alive;
        r_b.cur    <= eff_cur;
        r_c.start  <= r_b.start;
        r_c.is_end <= r_b.is_end;
        r_c.enter  <= b_enter;
        r_pend_end <= n_pend_end;
        r_pend_sym <= n_pend_sym;
        if (!i_rst_n) begin
            r_start_state <= '0;
            r_start_sym   <= dmpm_pkg::SYM_W'(2);
            r_end_sym     <= dmpm_pkg::SYM_W'(3);
            r_cur         <= '0;
            r_alive       <= 1'b0;
            r_best        <= '0;
            r_pend_v      <= 1'b0;
            r_b.v         <= 1'b0;
            r_c.v         <= 1'b0;
        end else begin
            r_pend_v <= n_pend_v;
            r_b.v    <= iss_v;
            r_c.v    <= r_b.v;
            if (r_b.v) begin
                r_cur   <= b_cur;
                r_alive <= b_alive;
            end
            if (r_c.v) begin
                r_best <= r_c.is_end ? '0 : c_best;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dmpm_pkg::CFG_START_STATE: r_start_state <= i_cfg_wdata;
                    dmpm_pkg::CFG_START_SYM:   r_start_sym   <= i_cfg_wdata;
                    dmpm_pkg::CFG_END_SYM:     r_end_sym     <= i_cfg_wdata;
                    default:                   r_end_sym     <= r_end_sym;
                endcase
            end
        end
    end

endmodule
